// ===== rtl/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// an implication checked at every clock edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fmha_pkg.sv =====
// ---------------------------------------------------------------------------
// fmha_pkg
// types and constants of the fit mode heap allocator
// ---------------------------------------------------------------------------
`default_nettype none
package fmha_pkg;

  localparam int unsigned MaxBlocksDef    = 64;
  localparam int unsigned HeapAddrBitsDef = 20;
  localparam int unsigned HeaderBytesDef  = 32;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = HeapAddrBitsDef + 1;

  localparam logic [CfgDataW-1:0] HeapBytesRst = CfgDataW'(1048576);

  localparam logic [CfgIdxW-1:0] CFG_FIT_MODE   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEAP_BYTES = 1'd1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXCEEDS  = 3'd1;
  localparam logic [2:0] ST_NO_HOLE  = 3'd2;
  localparam logic [2:0] ST_NOT_LIVE = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic                       action;
    logic [HeapAddrBitsDef:0]   request_bytes;
    logic [HeapAddrBitsDef-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]                 status;
    logic [HeapAddrBitsDef-1:0] block_offset;
    logic [HeapAddrBitsDef:0]   granted_bytes;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_LINK,
    S_LINK_PREV,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/fit_mode_heap_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// fit_mode_heap_allocator_unit
// heap allocator over an address-ordered table of occupied blocks
// ---------------------------------------------------------------------------
// usage:
//   a request beat is taken when start_i is high and busy_o is low; it either
//   allocates request_bytes (plus one header) or frees the block whose header
//   sits at free_offset
//   the answer is shown on rsp_o for one cycle with done_o high; the receiver
//   cannot hold it off, so nothing ever stalls on the result side
//   the occupied blocks live in one table memory (start, payload, next) with
//   a registered read; the walk reads the first entry at the accepting edge,
//   then each further entry in a read state followed by an evaluate state
//   an early error goes straight to done; an allocate walks the list, then writes
//   the new entry and, if it has a left neighbour, that entry too; a free walks
//   to the matching entry and unlinks it; busy_o drops in the cycle after done
//   all table writes finish before done, so the next walk reads fresh data
//   config writes (cfg_we_i, cfg_idx_i, cfg_data_i) land at once; the user
//   makes them only while idle, the block does not enforce it
//   reset clears the live bits, head pointer, state and config registers; table
//   contents are undefined until written, so no clearing pass is needed
//   a free-slot search runs as a priority encode over the live flip-flops
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fit_mode_heap_allocator_unit #(
  parameter int unsigned MAX_BLOCKS     = fmha_pkg::MaxBlocksDef,
  parameter int unsigned HEADER_BYTES   = fmha_pkg::HeaderBytesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire fmha_pkg::req_t                req_i,
  output logic                               done_o,
  output fmha_pkg::rsp_t                     rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [fmha_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fmha_pkg::CfgDataW-1:0] cfg_data_i
);
  import fmha_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned PW = IW + 1;
  localparam int unsigned AW = HeapAddrBitsDef;
  // sums of starts, headers and payloads stay below this width
  localparam int unsigned SW = AW + 3;
  localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] CAP = SW'(1) << AW;
  localparam logic [PW-1:0] NONE = PW'(MAX_BLOCKS);

  // table memory, one entry per block
  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW:0]   payload;
    logic [IW-1:0] next;
  } ent_t;
  ent_t mem [MAX_BLOCKS];

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  ent_t             mem_wdata;
  logic [IW-1:0]    mem_raddr;
  ent_t             mem_rdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // control and config registers
  state_e            state_q, state_d;
  logic [1:0]        mode_q;
  logic [AW:0]       heap_q;
  logic [MAX_BLOCKS-1:0] live_q, live_d;
  logic [PW-1:0]     head_q, head_d;
  req_t              req_q, req_d;
  logic [PW-1:0]     cur_q, cur_d, prev_q, prev_d;
  logic [SW-1:0]     hstart_q, hstart_d;
  logic              found_q, found_d;
  logic [SW-1:0]     bsize_q, bsize_d, bstart_q, bstart_d;
  logic [PW-1:0]     bprev_q, bprev_d;
  logic [PW-1:0]     slot_q, slot_d;
  rsp_t              rsp_q, rsp_d;
  // matched free block, entry of the previous list node, entry left of the pick
  ent_t              hit_q, hit_d;
  ent_t              pent_q, pent_d;
  ent_t              bent_q, bent_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= FIT_FIRST;
      heap_q  <= HeapBytesRst;
      live_q  <= '0;
      head_q  <= NONE;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      head_q  <= head_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FIT_MODE:   mode_q <= cfg_data_i[1:0];
          CFG_HEAP_BYTES: heap_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    hstart_q <= hstart_d;
    found_q  <= found_d;
    bsize_q  <= bsize_d;
    bstart_q <= bstart_d;
    bprev_q  <= bprev_d;
    slot_q   <= slot_d;
    rsp_q    <= rsp_d;
    hit_q    <= hit_d;
    pent_q   <= pent_d;
    bent_q   <= bent_d;
  end

  // heap limit clamp
  logic [SW-1:0] heap_lim;
  assign heap_lim = (SW'(heap_q) > CAP) ? CAP : SW'(heap_q);

  // lowest free slot
  logic [PW-1:0] free_slot;
  always_comb begin
    free_slot = NONE;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!live_q[i]) free_slot = PW'(i);
    end
  end

  logic [SW-1:0] total;
  assign total = SW'(req_q.request_bytes) + HDR;

  // successors of the entry just read, of the freed block, of the pick's left side
  logic [PW-1:0] succ, hsucc, bsucc;
  assign succ  = (PW'(mem_rdata.next) == cur_q) ? NONE : PW'(mem_rdata.next);
  assign hsucc = (PW'(hit_q.next) == cur_q) ? NONE : PW'(hit_q.next);
  assign bsucc = (PW'(bent_q.next) == bprev_q) ? NONE : PW'(bent_q.next);

  // hole ending at cur (or at the heap end)
  logic [SW-1:0] hend, hsize, rd_end;
  logic          fits, take, stop;
  assign rd_end = SW'(mem_rdata.start) + HDR + SW'(mem_rdata.payload);

  always_comb begin
    hend  = (cur_q == NONE) ? heap_lim : SW'(mem_rdata.start);
    hsize = (hend > hstart_q) ? hend - hstart_q : '0;
    fits  = hsize >= total;
    take  = 1'b0;
    stop  = 1'b0;
    if (fits) begin
      unique case (mode_q)
        FIT_BEST:  take = !found_q || hsize < bsize_q;
        FIT_WORST: take = !found_q || hsize > bsize_q;
        default:   take = 1'b1;
      endcase
      if (take) begin
        stop = (mode_q != FIT_BEST && mode_q != FIT_WORST) ||
               (mode_q == FIT_BEST && hsize == total);
      end
    end
  end

  // slack smaller than a header goes into the grant
  logic [SW-1:0] gpay;
  assign gpay = (bsize_q - total < HDR) ? bsize_q - HDR : SW'(req_q.request_bytes);

  always_comb begin
    state_d   = state_q;
    live_d    = live_q;
    head_d    = head_q;
    req_d     = req_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    hstart_d  = hstart_q;
    found_d   = found_q;
    bsize_d   = bsize_q;
    bstart_d  = bstart_q;
    bprev_d   = bprev_q;
    slot_d    = slot_q;
    rsp_d     = rsp_q;
    hit_d     = hit_q;
    pent_d    = pent_q;
    bent_d    = bent_q;
    mem_we    = 1'b0;
    mem_waddr = slot_q[IW-1:0];
    mem_wdata = '0;
    mem_raddr = cur_q[IW-1:0];
    busy_o    = 1'b1;
    done_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          req_d    = req_i;
          cur_d    = head_q;
          prev_d   = NONE;
          hstart_d = '0;
          found_d  = 1'b0;
          bsize_d  = '0;
          bstart_d = '0;
          bprev_d  = NONE;
          slot_d   = free_slot;
          rsp_d    = '0;
          mem_raddr = head_q[IW-1:0];
          state_d  = S_EVAL;
          if (req_i.action == ACT_ALLOC) begin
            if (SW'(req_i.request_bytes) + HDR > heap_lim) begin
              rsp_d.status = ST_EXCEEDS;
              state_d = S_DONE;
            end else if (free_slot == NONE) begin
              rsp_d.status = ST_FULL;
              state_d = S_DONE;
            end
          end else if (head_q == NONE) begin
            rsp_d.status = ST_NOT_LIVE;
            state_d = S_DONE;
          end
        end
      end
      S_READ: begin
        // memory address is cur_q; data arrives next cycle
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (req_q.action == ACT_FREE) begin
          if (mem_rdata.start == req_q.free_offset) begin
            hit_d   = mem_rdata;
            state_d = S_LINK;
          end else if (succ == NONE) begin
            rsp_d.status = ST_NOT_LIVE;
            state_d = S_DONE;
          end else begin
            pent_d  = mem_rdata;
            prev_d  = cur_q;
            cur_d   = succ;
            state_d = S_READ;
          end
        end else begin
          if (take) begin
            found_d  = 1'b1;
            bsize_d  = hsize;
            bstart_d = hstart_q;
            bprev_d  = prev_q;
            bent_d   = pent_q;
          end
          if (stop || cur_q == NONE) begin
            if (found_q || take) begin
              state_d = S_LINK;
            end else begin
              rsp_d.status = ST_NO_HOLE;
              state_d = S_DONE;
            end
          end else begin
            hstart_d = rd_end;
            prev_d   = cur_q;
            pent_d   = mem_rdata;
            cur_d    = succ;
            state_d  = S_READ;
          end
        end
      end
      S_LINK: begin
        state_d = S_DONE;
        if (req_q.action == ACT_FREE) begin
          live_d[cur_q[IW-1:0]] = 1'b0;
          rsp_d.status        = ST_OK;
          rsp_d.block_offset  = req_q.free_offset;
          rsp_d.granted_bytes = hit_q.payload;
          if (prev_q == NONE) begin
            head_d = hsucc;
          end else begin
            // predecessor now points past the freed block, or to itself at the tail
            mem_we    = 1'b1;
            mem_waddr = prev_q[IW-1:0];
            mem_wdata = pent_q;
            mem_wdata.next = (hsucc == NONE) ? prev_q[IW-1:0] : hsucc[IW-1:0];
          end
        end else begin
          live_d[slot_q[IW-1:0]] = 1'b1;
          rsp_d.status        = ST_OK;
          rsp_d.block_offset  = bstart_q[AW-1:0];
          rsp_d.granted_bytes = gpay[AW:0];
          mem_we            = 1'b1;
          mem_waddr         = slot_q[IW-1:0];
          mem_wdata.start   = bstart_q[AW-1:0];
          mem_wdata.payload = gpay[AW:0];
          if (bprev_q == NONE) begin
            mem_wdata.next = (head_q == NONE) ? slot_q[IW-1:0] : head_q[IW-1:0];
            head_d = slot_q;
          end else begin
            mem_wdata.next = (bsucc == NONE) ? slot_q[IW-1:0] : bsucc[IW-1:0];
            state_d = S_LINK_PREV;
          end
        end
      end
      S_LINK_PREV: begin
        // left neighbor of the new block now points at it
        mem_we         = 1'b1;
        mem_waddr      = bprev_q[IW-1:0];
        mem_wdata      = bent_q;
        mem_wdata.next = slot_q[IW-1:0];
        state_d        = S_DONE;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_o = rsp_q;

  `ASSERT_IMPL(a_done_one, clk_i, rst_ni, done_o, !$past(done_o), "done held twice")
  `ASSERT_IMPL(a_busy_idle, clk_i, rst_ni, state_q == S_IDLE, !busy_o, "busy in idle")
  `ASSERT_IMPL(a_head_live, clk_i, rst_ni, head_q != NONE, live_q[head_q[IW-1:0]],
               "list head not live")
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, done_o && rsp_o.status != ST_OK,
               rsp_o.block_offset == '0, "error with offset")

endmodule
`default_nettype wire

// ===== bench/fit_mode_heap_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fit_mode_heap_allocator_unit_tb
// self-checking bench: directed table of requests, then random alloc/free
// traffic under every fit mode and several heap sizes, compared against an
// internal allocator model beat by beat
// ---------------------------------------------------------------------------
`default_nettype none
module fit_mode_heap_allocator_unit_tb;
  import fmha_pkg::*;

  localparam int unsigned NBLK   = MaxBlocksDef;
  localparam int unsigned HDR    = HeaderBytesDef;
  localparam longint      ADDR_CAP = 64'd1 << HeapAddrBitsDef;
  localparam int          NO_BLK = NBLK;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  fit_mode_heap_allocator_unit u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .rsp_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the block's table and registers
  logic [1:0]  mdl_mode;
  logic [20:0] mdl_heap;
  longint      blk_start [NBLK];
  longint      blk_pay   [NBLK];
  int          blk_next  [NBLK];
  bit          blk_live  [NBLK];
  int          blk_head;

  rsp_t  pending_rsp[$];
  int    n_errors = 0;
  int    n_beats = 0;
  int    n_ok = 0;
  int    n_err_rsp = 0;
  longint cycle_cnt = 0;

  function automatic int next_of(int idx);
    return (blk_next[idx] == idx || blk_next[idx] >= NBLK) ? NO_BLK : blk_next[idx];
  endfunction

  function automatic rsp_t run_alloc(longint want);
    rsp_t   r;
    longint heap, total, hstart, size, best_start, best_size, payload;
    int     slot, prev, cur, best_prev, after;
    bit     found, take;
    r = '0;
    heap = (longint'(mdl_heap) > ADDR_CAP) ? ADDR_CAP : longint'(mdl_heap);
    total = want + HDR;
    if (total > heap) begin
      r.status = ST_EXCEEDS;
      return r;
    end
    slot = NO_BLK;
    for (int i = 0; i < NBLK; i++) if (!blk_live[i] && slot == NO_BLK) slot = i;
    if (slot == NO_BLK) begin
      r.status = ST_FULL;
      return r;
    end
    prev = NO_BLK; cur = blk_head; best_prev = NO_BLK;
    hstart = 0; best_start = 0; best_size = 0; found = 0;
    for (int step = 0; step <= NBLK; step++) begin
      longint hend;
      hend = (cur == NO_BLK) ? heap : blk_start[cur];
      size = (hend > hstart) ? hend - hstart : 0;
      if (size >= total) begin
        if (mdl_mode == FIT_BEST) take = !found || size < best_size;
        else if (mdl_mode == FIT_WORST) take = !found || size > best_size;
        else take = 1;
        if (take) begin
          found = 1; best_size = size; best_start = hstart; best_prev = prev;
          if (mdl_mode != FIT_BEST && mdl_mode != FIT_WORST) break;
          if (mdl_mode == FIT_BEST && size == total) break;
        end
      end
      if (cur == NO_BLK) break;
      hstart = blk_start[cur] + HDR + blk_pay[cur];
      prev = cur;
      cur = next_of(cur);
    end
    if (!found) begin
      r.status = ST_NO_HOLE;
      return r;
    end
    payload = want;
    if (best_size - total < HDR) payload = best_size - HDR;
    blk_start[slot] = best_start & (ADDR_CAP - 1);
    blk_pay[slot] = payload & (2 * ADDR_CAP - 1);
    blk_live[slot] = 1;
    if (best_prev == NO_BLK) begin
      blk_next[slot] = (blk_head == NO_BLK) ? slot : blk_head;
      blk_head = slot;
    end else begin
      after = next_of(best_prev);
      blk_next[slot] = (after == NO_BLK) ? slot : after;
      blk_next[best_prev] = slot;
    end
    r.status = ST_OK;
    r.block_offset = blk_start[slot][19:0];
    r.granted_bytes = blk_pay[slot][20:0];
    return r;
  endfunction

  function automatic rsp_t run_free(longint off);
    rsp_t r;
    int   prev, cur, after;
    r = '0;
    prev = NO_BLK; cur = blk_head;
    for (int step = 0; step < NBLK && cur != NO_BLK; step++) begin
      if (blk_live[cur] && blk_start[cur] == off) break;
      prev = cur;
      cur = next_of(cur);
    end
    if (cur == NO_BLK || !blk_live[cur] || blk_start[cur] != off) begin
      r.status = ST_NOT_LIVE;
      return r;
    end
    after = next_of(cur);
    if (prev == NO_BLK) blk_head = after;
    else blk_next[prev] = (after == NO_BLK) ? prev : after;
    blk_live[cur] = 0;
    r.status = ST_OK;
    r.block_offset = off[19:0];
    r.granted_bytes = blk_pay[cur][20:0];
    return r;
  endfunction

  function automatic rsp_t predict_heap(req_t q);
    if (q.action == ACT_ALLOC) return run_alloc(longint'(q.request_bytes));
    return run_free(longint'(q.free_offset));
  endfunction

  // result checker: receiver cannot stall, so every done beat is taken
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected beat expected none actual %p", $time, rsp_o);
        n_errors++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (e.status !== rsp_o.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_o.status);
        if (e.block_offset !== rsp_o.block_offset)
          $display("%0t: block_offset expected %0h actual %0h", $time,
                   e.block_offset, rsp_o.block_offset);
        if (e.granted_bytes !== rsp_o.granted_bytes)
          $display("%0t: granted_bytes expected %0h actual %0h", $time,
                   e.granted_bytes, rsp_o.granted_bytes);
        if (e !== rsp_o) n_errors++;
        if (rsp_o.status == ST_OK) n_ok++; else n_err_rsp++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("fit_mode_heap_allocator_unit verification failed");
      $finish;
    end
  end

  // sender burst state
  int burst_left = 0;

  // one request beat; optional check against a typed-in answer
  // start_i stays high inside a burst; this task drops it only for a gap
  task automatic send_req(req_t q, bit has_gold, rsp_t gold);
    rsp_t p;
    int   gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start_i <= 1'b1;
    req_i <= q;
    do @(posedge clk_i); while (busy_o);
    p = predict_heap(q);
    if (has_gold && p !== gold) begin
      $display("%0t: table row expected %p model %p", $time, gold, p);
      n_errors++;
    end
    pending_rsp.insert(pending_rsp.size(), p);
    n_beats++;
  endtask

  task automatic drain_all();
    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (2 * NBLK + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FIT_MODE) mdl_mode = val[1:0];
    else mdl_heap = val;
    @(posedge clk_i);
  endtask

  function automatic req_t mk(logic act, logic [20:0] nb, logic [19:0] off);
    req_t q;
    q.action = act; q.request_bytes = nb; q.free_offset = off;
    return q;
  endfunction

  function automatic rsp_t ans(logic [2:0] st, logic [19:0] off, logic [20:0] nb);
    rsp_t r;
    r.status = st; r.block_offset = off; r.granted_bytes = nb;
    return r;
  endfunction

  typedef struct {
    req_t q;
    bit   gold;
    rsp_t r;
  } row_t;

  row_t dir_rows[$];

  function automatic void add_row(req_t q, bit gold, rsp_t r);
    row_t w;
    w.q = q; w.gold = gold; w.r = r;
    dir_rows.insert(dir_rows.size(), w);
  endfunction

  // pick an offset of a live block, if any
  function automatic longint live_offset();
    int cand[$];
    for (int i = 0; i < NBLK; i++) if (blk_live[i]) cand.insert(cand.size(), i);
    if (cand.size() == 0) return 0;
    return blk_start[cand[$urandom_range(0, cand.size() - 1)]];
  endfunction

  function automatic int live_count();
    int c;
    c = 0;
    for (int i = 0; i < NBLK; i++) c += blk_live[i];
    return c;
  endfunction

  initial begin
    int sel;
    req_t q;
    mdl_mode = FIT_FIRST;
    mdl_heap = HeapBytesRst;
    for (int i = 0; i < NBLK; i++) begin
      blk_start[i] = 0; blk_pay[i] = 0; blk_next[i] = 0; blk_live[i] = 0;
    end
    blk_head = NO_BLK;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset values, extremes, error codes
    add_row(mk(ACT_FREE, 21'd0, 20'd0), 1'b1, ans(ST_NOT_LIVE, '0, '0));
    add_row(mk(ACT_ALLOC, 21'h1FFFFF, 20'hFFFFF), 1'b1, ans(ST_EXCEEDS, '0, '0));
    add_row(mk(ACT_ALLOC, 21'd1048576, 20'd0), 1'b1, ans(ST_EXCEEDS, '0, '0));
    add_row(mk(ACT_ALLOC, 21'd0, 20'hFFFFF), 1'b1, ans(ST_OK, '0, '0));
    add_row(mk(ACT_ALLOC, 21'd100, 20'd0), 1'b1, ans(ST_OK, 20'd32, 21'd100));
    add_row(mk(ACT_FREE, 21'd0, 20'd32), 1'b1, ans(ST_OK, 20'd32, 21'd100));
    add_row(mk(ACT_FREE, 21'd0, 20'd33), 1'b1, ans(ST_NOT_LIVE, '0, '0));
    add_row(mk(ACT_ALLOC, 21'd90, 20'd0), 1'b0, '0);
    add_row(mk(ACT_ALLOC, 21'd1048576 - 21'd400, 20'd0), 1'b0, '0);
    add_row(mk(ACT_ALLOC, 21'd500, 20'd0), 1'b0, '0);
    add_row(mk(ACT_FREE, 21'd0, 20'hFFFFF), 1'b1, ans(ST_NOT_LIVE, '0, '0));
    add_row(mk(ACT_FREE, 21'd0, 20'd0), 1'b1, ans(ST_OK, '0, '0));
    foreach (dir_rows[i]) send_req(dir_rows[i].q, dir_rows[i].gold, dir_rows[i].r);
    while (live_count() > 0) send_req(mk(ACT_FREE, 21'd0, 20'(live_offset())), 1'b0, '0);
    drain_all();

    // fill the table to hit table full, on a small heap
    write_reg(CFG_HEAP_BYTES, 21'd4096);
    for (int i = 0; i < NBLK + 2; i++) send_req(mk(ACT_ALLOC, 21'd0, 20'd0), 1'b0, '0);
    send_req(mk(ACT_ALLOC, 21'd5000, 20'd0), 1'b1, ans(ST_EXCEEDS, '0, '0));
    drain_all();
    // shrink heap under live blocks, then free everything
    write_reg(CFG_HEAP_BYTES, 21'd1);
    send_req(mk(ACT_ALLOC, 21'd0, 20'd0), 1'b1, ans(ST_EXCEEDS, '0, '0));
    while (live_count() > 0) send_req(mk(ACT_FREE, 21'd0, 20'(live_offset())), 1'b0, '0);
    drain_all();
    write_reg(CFG_HEAP_BYTES, 21'd0);
    send_req(mk(ACT_ALLOC, 21'd0, 20'd0), 1'b1, ans(ST_EXCEEDS, '0, '0));
    drain_all();

    // random phases across modes and heap sizes (including the oversized one)
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FIT_MODE, CfgDataW'(ph % 4));
      unique case (ph)
        0: write_reg(CFG_HEAP_BYTES, 21'h1FFFFF);
        1: write_reg(CFG_HEAP_BYTES, 21'd1048576);
        2: write_reg(CFG_HEAP_BYTES, 21'd2048);
        3: write_reg(CFG_HEAP_BYTES, 21'd32);
        default: write_reg(CFG_HEAP_BYTES, CfgDataW'($urandom_range(64, 200000)));
      endcase
      for (int n = 0; n < 64; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45)
          q = mk(ACT_ALLOC, (ph < 2 && $urandom_range(0, 9) == 0) ?
                 21'($urandom()) : 21'($urandom_range(0, mdl_heap / 8 + 40)),
                 20'($urandom()));
        else if (sel < 85)
          q = mk(ACT_FREE, 21'($urandom()), 20'(live_offset()));
        else
          q = mk(1'($urandom_range(0, 1)), 21'($urandom()), 20'($urandom()));
        send_req(q, 1'b0, '0);
      end
      // hold off until every answer is back
      drain_all();
    end

    $display("covered %0d request beats: %0d granted or freed, %0d refused",
             n_beats, n_ok, n_err_rsp);
    $display("all four fit mode codes, heap sizes from zero to oversized, table full");
    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("fit_mode_heap_allocator_unit verification clean");
    end else begin
      $display("fit_mode_heap_allocator_unit verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/fmha_pkg.sv
rtl/fit_mode_heap_allocator_unit.sv
bench/fit_mode_heap_allocator_unit_tb.sv
